/* hdl/chacha_keystream_generator_macros.svh */
// Assertion macros used by the checker file.
`ifndef CHACHA_KEYSTREAM_GENERATOR_MACROS_SVH
`define CHACHA_KEYSTREAM_GENERATOR_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CKG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication outside reset.
`define CKG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* hdl/ckg_pkg.sv */
// Shared constants, types and functions of the ChaCha keystream generator.
package ckg_pkg;
	localparam int ROUNDS = 20;
	localparam int DOUBLE_ROUNDS = (ROUNDS + 1) / 2;
	localparam int DR_W = $clog2(DOUBLE_ROUNDS + 1);
	localparam int KEY_WORDS = 8;
	localparam int CFG_IDX_W = 3;
	localparam logic OP_GENERATE = 1'b0;
	localparam logic OP_SET_COUNTER = 1'b1;
	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646E;
	localparam logic [31:0] SIGMA2 = 32'h79622D32;
	localparam logic [31:0] SIGMA3 = 32'h6B206574;

	typedef logic [31:0] word_t;
	typedef word_t [15:0] block_t;

	// Classified command handed from front to back.
	typedef struct packed {
		logic op;
		logic [127:0] ctr;
	} cmd_t;

	function automatic word_t rotl(input word_t v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	// One quarter round on four words, returned as {a,b,c,d}.
	function automatic logic [127:0] qr(input word_t a0, input word_t b0,
		input word_t c0, input word_t d0);
		word_t a, b, c, d;
		a = a0 + b0; d = rotl(d0 ^ a, 16);
		c = c0 + d;  b = rotl(b0 ^ c, 12);
		a = a + b;   d = rotl(d ^ a, 8);
		c = c + d;   b = rotl(b ^ c, 7);
		qr = {a, b, c, d};
	endfunction
endpackage

/* hdl/ckg_front.sv */
// Front end: takes input commands into a two-entry command queue.
module ckg_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  ckg_pkg::cmd_t in_cmd,
	output logic cmd_valid,
	input  logic cmd_take,
	output ckg_pkg::cmd_t cmd
);
	ckg_pkg::cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop = cmd_valid && cmd_take;
	assign cmd = mem_q[rp_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_cmd;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

/* hdl/ckg_back.sv */
// Back end: counter, double-round core with four quarter-round units, word output.
module ckg_back (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ckg_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0] cfg_data,
	input  logic cmd_valid,
	output logic cmd_take,
	input  ckg_pkg::cmd_t cmd,
	output logic out_valid,
	input  logic out_stall,
	output logic [31:0] random_word,
	output logic [3:0] word_position,
	output logic last_word
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_COL = 2'd1;
	localparam logic [1:0] ST_DIAG = 2'd2;

	ckg_pkg::word_t key_q [ckg_pkg::KEY_WORDS];
	logic [127:0] ctr_q;
	ckg_pkg::block_t x_q, init_q, res_q;
	logic [1:0] st_q;
	logic [ckg_pkg::DR_W-1:0] dr_q;
	logic busy_out_q;
	logic [3:0] pos_q;
	logic [127:0] q0, q1, q2, q3;
	ckg_pkg::block_t init_n, nxt;
	logic done_core, out_take, start_gen;

	// Input state for the next block
	always_comb begin
		init_n[0] = ckg_pkg::SIGMA0;
		init_n[1] = ckg_pkg::SIGMA1;
		init_n[2] = ckg_pkg::SIGMA2;
		init_n[3] = ckg_pkg::SIGMA3;
		for (int i = 0; i < ckg_pkg::KEY_WORDS; i++) init_n[4 + i] = key_q[i];
		for (int i = 0; i < 4; i++) init_n[12 + i] = ctr_q[32*i +: 32];
	end

	// Four shared quarter-round units: column or diagonal step
	always_comb begin
		nxt = x_q;
		if (st_q == ST_COL) begin
			q0 = ckg_pkg::qr(x_q[0], x_q[4], x_q[8], x_q[12]);
			q1 = ckg_pkg::qr(x_q[1], x_q[5], x_q[9], x_q[13]);
			q2 = ckg_pkg::qr(x_q[2], x_q[6], x_q[10], x_q[14]);
			q3 = ckg_pkg::qr(x_q[3], x_q[7], x_q[11], x_q[15]);
			{nxt[0], nxt[4], nxt[8], nxt[12]} = q0;
			{nxt[1], nxt[5], nxt[9], nxt[13]} = q1;
			{nxt[2], nxt[6], nxt[10], nxt[14]} = q2;
			{nxt[3], nxt[7], nxt[11], nxt[15]} = q3;
		end else begin
			q0 = ckg_pkg::qr(x_q[0], x_q[5], x_q[10], x_q[15]);
			q1 = ckg_pkg::qr(x_q[1], x_q[6], x_q[11], x_q[12]);
			q2 = ckg_pkg::qr(x_q[2], x_q[7], x_q[8], x_q[13]);
			q3 = ckg_pkg::qr(x_q[3], x_q[4], x_q[9], x_q[14]);
			{nxt[0], nxt[5], nxt[10], nxt[15]} = q0;
			{nxt[1], nxt[6], nxt[11], nxt[12]} = q1;
			{nxt[2], nxt[7], nxt[8], nxt[13]} = q2;
			{nxt[3], nxt[4], nxt[9], nxt[14]} = q3;
		end
	end

	assign done_core = (st_q == ST_DIAG) &&
		(dr_q == ckg_pkg::DR_W'(ckg_pkg::DOUBLE_ROUNDS - 1)) && !busy_out_q;
	assign start_gen = cmd_valid && (st_q == ST_IDLE) && (cmd.op == ckg_pkg::OP_GENERATE);
	assign cmd_take = (st_q == ST_IDLE) && cmd_valid;
	assign out_valid = busy_out_q;
	assign out_take = busy_out_q && !out_stall;
	assign random_word = res_q[pos_q];
	assign word_position = pos_q;
	assign last_word = (pos_q == 4'd15);

	// Key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ckg_pkg::KEY_WORDS; i++) key_q[i] <= '0;
		end else if (cfg_we) begin
			key_q[cfg_idx] <= cfg_data;
		end
	end

	// Round sequencer and block counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			dr_q <= '0;
			ctr_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (cmd_valid && cmd.op == ckg_pkg::OP_SET_COUNTER) begin
						ctr_q <= cmd.ctr;
					end else if (start_gen) begin
						st_q <= ST_COL;
						dr_q <= '0;
					end
				end
				ST_COL: st_q <= ST_DIAG;
				ST_DIAG: begin
					if (dr_q != ckg_pkg::DR_W'(ckg_pkg::DOUBLE_ROUNDS - 1)) begin
						st_q <= ST_COL;
						dr_q <= dr_q + 1'b1;
					end else if (done_core) begin
						st_q <= ST_IDLE;
						ctr_q <= ctr_q + 128'd1;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Working state and feed-forward
	always_ff @(posedge clk) begin
		if (start_gen) begin
			x_q <= init_n;
			init_q <= init_n;
		end else if (st_q == ST_COL || (st_q == ST_DIAG &&
			dr_q != ckg_pkg::DR_W'(ckg_pkg::DOUBLE_ROUNDS - 1))) begin
			x_q <= nxt;
		end else if (done_core) begin
			for (int i = 0; i < 16; i++) res_q[i] <= nxt[i] + init_q[i];
		end
	end

	// Output word sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_out_q <= 1'b0;
			pos_q <= '0;
		end else if (done_core) begin
			busy_out_q <= 1'b1;
			pos_q <= '0;
		end else if (out_take) begin
			pos_q <= pos_q + 4'd1;
			if (pos_q == 4'd15) busy_out_q <= 1'b0;
		end
	end
endmodule

/* hdl/chacha_keystream_generator.sv */
// Block ChaCha keystream generator: block rounds run while the previous block drains, one
// column or diagonal step per cycle in four shared quarter-round units, so a block
// takes ROUNDS (20) column and diagonal steps after its start in the idle state. With a
// ready sink the sixteen-word output of one block overlaps the rounds of the next, and
// the block rate is set by the rounds; the last round step of a block waits until every
// word of the previous block has been taken. Counter loads are taken in the idle state.
module chacha_keystream_generator (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic operation,
	input  logic [63:0] counter_low_half,
	input  logic [63:0] counter_high_half,
	output logic out_valid,
	input  logic out_stall,
	output logic [31:0] random_word,
	output logic [3:0] word_position,
	output logic last_word
);
	ckg_pkg::cmd_t in_cmd, cmd;
	logic cmd_valid, cmd_take;

	assign in_cmd.op = operation;
	assign in_cmd.ctr = {counter_high_half, counter_low_half};

	ckg_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_cmd(in_cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	ckg_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_index),
		.cfg_data(cfg_data), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
		.out_valid(out_valid), .out_stall(out_stall), .random_word(random_word),
		.word_position(word_position), .last_word(last_word)
	);
endmodule

/* hdl/ckg_checker.sv */
// Port-level checker for the keystream generator, bound to the top level.
`include "chacha_keystream_generator_macros.svh"
module ckg_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic [31:0] random_word,
	input logic [3:0] word_position,
	input logic last_word
);
	`CKG_ASSERT_IMP(a_last_pos, clk, arst_n, out_valid, (last_word == (word_position == 4'd15)), "last flag mismatch")
	`CKG_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(random_word) && $stable(word_position), "stalled word changed")
	`CKG_ASSERT_NXT(a_seq, clk, arst_n, out_valid && !out_stall && !last_word, out_valid && (word_position == $past(word_position) + 4'd1), "word positions out of order")
endmodule

bind chacha_keystream_generator ckg_checker u_ckg_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.random_word(random_word), .word_position(word_position), .last_word(last_word)
);
